>>> design/gpioic_pkg.sv
// Shared types, register offsets and helpers for the GPIO interrupt controller.
// No dependencies; imported by gpioic_core, gpio_interrupt_controller and the sim files.
package gpioic_pkg;

    localparam int          NUM_PINS_DEFAULT   = 32;
    localparam logic [31:0] VERSION_ID_DEFAULT = 32'h0000_0000;

    localparam int ADDR_W  = 7;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 5;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_TICK  = 2'd2
    } gpioic_action_t;

    // Register byte offsets, word aligned
    localparam logic [ADDR_W-1:0] ADDR_ENABLE_LO   = 7'h10;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE_HI   = 7'h14;
    localparam logic [ADDR_W-1:0] ADDR_MASK_LO     = 7'h18;
    localparam logic [ADDR_W-1:0] ADDR_MASK_HI     = 7'h1c;
    localparam logic [ADDR_W-1:0] ADDR_TYPE_LO     = 7'h20;
    localparam logic [ADDR_W-1:0] ADDR_TYPE_HI     = 7'h24;
    localparam logic [ADDR_W-1:0] ADDR_POLARITY_LO = 7'h28;
    localparam logic [ADDR_W-1:0] ADDR_POLARITY_HI = 7'h2c;
    localparam logic [ADDR_W-1:0] ADDR_BOTH_LO     = 7'h30;
    localparam logic [ADDR_W-1:0] ADDR_BOTH_HI     = 7'h34;
    localparam logic [ADDR_W-1:0] ADDR_STATUS      = 7'h50;
    localparam logic [ADDR_W-1:0] ADDR_RAW_STATUS  = 7'h58;
    localparam logic [ADDR_W-1:0] ADDR_EOI_LO      = 7'h60;
    localparam logic [ADDR_W-1:0] ADDR_EOI_HI      = 7'h64;
    localparam logic [ADDR_W-1:0] ADDR_VERSION     = 7'h78;

    typedef struct packed {
        gpioic_action_t    action;
        logic [ADDR_W-1:0] reg_addr;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] pin_levels;
    } gpioic_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               irq_line;
        logic               pending_any;
        logic [INDEX_W-1:0] lowest_pending;
    } gpioic_res_t;

    // Index of the lowest set bit: isolate it, then encode the one-hot word.
    function automatic logic [INDEX_W-1:0] lowest_index(input logic [DATA_W-1:0] st);
        logic [DATA_W-1:0]  onehot;
        logic [INDEX_W-1:0] idx;
        onehot = st & (~st + 32'd1);
        idx    = '0;
        for (int b = 0; b < INDEX_W; b++)
        begin
            for (int i = 0; i < DATA_W; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    idx[b] = idx[b] | onehot[i];
                end
            end
        end
        return idx;
    endfunction

endpackage

>>> design/gpioic_core.sv
// Per-pin interrupt state, register file and status logic of the controller.
// Depends on gpioic_pkg; state advances once for each request handed in.
module gpioic_core #(
    parameter int          NUM_PINS   = gpioic_pkg::NUM_PINS_DEFAULT,
    parameter logic [31:0] VERSION_ID = gpioic_pkg::VERSION_ID_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  gpioic_pkg::gpioic_req_t req,
    output gpioic_pkg::gpioic_res_t res
);
    import gpioic_pkg::*;

    localparam logic [DATA_W-1:0] PIN_MASK = DATA_W'((64'd1 << NUM_PINS) - 64'd1);

    logic [DATA_W-1:0] enable_reg,   enable_next;
    logic [DATA_W-1:0] mask_reg,     mask_next;
    logic [DATA_W-1:0] type_reg,     type_next;
    logic [DATA_W-1:0] polarity_reg, polarity_next;
    logic [DATA_W-1:0] both_reg,     both_next;
    logic [DATA_W-1:0] prev_reg,     prev_next;
    logic [DATA_W-1:0] latched_reg,  latched_next;

    logic [ADDR_W-1:0] addr;
    logic              high;
    logic [DATA_W-1:0] wr_en;
    logic [DATA_W-1:0] wr_val;
    logic [DATA_W-1:0] pins;
    logic [DATA_W-1:0] rise;
    logic [DATA_W-1:0] fall;
    logic [DATA_W-1:0] hit;
    logic [DATA_W-1:0] raw_cur;
    logic [DATA_W-1:0] raw_new;
    logic [DATA_W-1:0] status_new;
    logic [DATA_W-1:0] rd;

    function automatic logic [DATA_W-1:0] raw_of(
        input logic [DATA_W-1:0] en,
        input logic [DATA_W-1:0] ty,
        input logic [DATA_W-1:0] pol,
        input logic [DATA_W-1:0] both,
        input logic [DATA_W-1:0] prev,
        input logic [DATA_W-1:0] lat
    );
        logic [DATA_W-1:0] em;
        logic [DATA_W-1:0] lvl;
        em  = ty | both;
        lvl = ~em & ~(prev ^ pol);
        return en & ((lat & em) | lvl) & PIN_MASK;
    endfunction

    function automatic logic [DATA_W-1:0] half_of(input logic [DATA_W-1:0] v, input logic hi);
        return hi ? {16'h0000, v[31:16]} : {16'h0000, v[15:0]};
    endfunction

    assign addr = {req.reg_addr[ADDR_W-1:2], 2'b00};
    assign high = req.reg_addr[2];
    assign pins = req.pin_levels & PIN_MASK;

    // Upper half of the write data enables the lower half, bit for bit
    assign wr_en  = high ? {req.write_data[31:16], 16'h0000} : {16'h0000, req.write_data[31:16]};
    assign wr_val = high ? {req.write_data[15:0], 16'h0000}  : {16'h0000, req.write_data[15:0]};

    assign rise = pins & ~prev_reg;
    assign fall = ~pins & prev_reg;
    assign hit  = (both_reg & (rise | fall))
                | (~both_reg & type_reg & ((polarity_reg & rise) | (~polarity_reg & fall)));

    assign raw_cur = raw_of(enable_reg, type_reg, polarity_reg, both_reg, prev_reg, latched_reg);

    always_comb
    begin
        enable_next   = enable_reg;
        mask_next     = mask_reg;
        type_next     = type_reg;
        polarity_next = polarity_reg;
        both_next     = both_reg;
        prev_next     = prev_reg;
        latched_next  = latched_reg;
        rd            = '0;
        unique case (req.action)
            ACT_WRITE:
            begin
                unique case (addr)
                    ADDR_ENABLE_LO, ADDR_ENABLE_HI:
                        enable_next = ((enable_reg & ~wr_en) | (wr_val & wr_en)) & PIN_MASK;
                    ADDR_MASK_LO, ADDR_MASK_HI:
                        mask_next = ((mask_reg & ~wr_en) | (wr_val & wr_en)) & PIN_MASK;
                    ADDR_TYPE_LO, ADDR_TYPE_HI:
                        type_next = ((type_reg & ~wr_en) | (wr_val & wr_en)) & PIN_MASK;
                    ADDR_POLARITY_LO, ADDR_POLARITY_HI:
                        polarity_next = ((polarity_reg & ~wr_en) | (wr_val & wr_en)) & PIN_MASK;
                    ADDR_BOTH_LO, ADDR_BOTH_HI:
                        both_next = ((both_reg & ~wr_en) | (wr_val & wr_en)) & PIN_MASK;
                    ADDR_EOI_LO, ADDR_EOI_HI:
                        latched_next = latched_reg & ~(wr_val & wr_en & PIN_MASK);
                    default:
                        latched_next = latched_reg;
                endcase
            end
            ACT_READ:
            begin
                unique case (addr)
                    ADDR_ENABLE_LO, ADDR_ENABLE_HI:     rd = half_of(enable_reg, high);
                    ADDR_MASK_LO, ADDR_MASK_HI:         rd = half_of(mask_reg, high);
                    ADDR_TYPE_LO, ADDR_TYPE_HI:         rd = half_of(type_reg, high);
                    ADDR_POLARITY_LO, ADDR_POLARITY_HI: rd = half_of(polarity_reg, high);
                    ADDR_BOTH_LO, ADDR_BOTH_HI:         rd = half_of(both_reg, high);
                    ADDR_STATUS:                        rd = raw_cur & ~mask_reg;
                    ADDR_RAW_STATUS:                    rd = raw_cur;
                    ADDR_VERSION:                       rd = VERSION_ID;
                    default:                            rd = '0;
                endcase
            end
            ACT_TICK:
            begin
                latched_next = latched_reg | (hit & enable_reg & PIN_MASK);
                prev_next    = pins;
            end
            default:
                rd = '0;
        endcase
    end

    // Reported status reflects the state after this request
    assign raw_new    = raw_of(enable_next, type_next, polarity_next, both_next,
                               prev_next, latched_next);
    assign status_new = raw_new & ~mask_next;

    assign res.read_data      = rd;
    assign res.irq_line       = |status_new;
    assign res.pending_any    = |status_new;
    assign res.lowest_pending = lowest_index(status_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= '0;
            mask_reg     <= '0;
            type_reg     <= '0;
            polarity_reg <= '0;
            both_reg     <= '0;
            prev_reg     <= '0;
            latched_reg  <= '0;
        end
        else if (req_valid)
        begin
            enable_reg   <= enable_next;
            mask_reg     <= mask_next;
            type_reg     <= type_next;
            polarity_reg <= polarity_next;
            both_reg     <= both_next;
            prev_reg     <= prev_next;
            latched_reg  <= latched_next;
        end
    end

endmodule

>>> design/gpio_interrupt_controller.sv
// Channel   | Dir | Handshake                   | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tuser: action; tdata: addr, wdata, pins
// m_axis    | out | m_axis_tvalid/m_axis_tready | tdata: read_data, irq, pending, lowest
//
// One request per clock while the result side is not stalled; an accepted request
// passes the input register, then the result register, before it can leave.
// Reset clears all per-pin state, the latched edges and both stage valids.
// A stalled result holds; the input register keeps taking requests until it
// is full behind the stalled result. Depends on gpioic_pkg and gpioic_core.
module gpio_interrupt_controller #(
    parameter int          NUM_PINS   = gpioic_pkg::NUM_PINS_DEFAULT,
    parameter logic [31:0] VERSION_ID = gpioic_pkg::VERSION_ID_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // reg_addr[6:0], write_data[38:7], pin_levels[70:39], 0
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // read_data[31:0], irq_line[32], pending_any[33],
                                       // lowest_pending[38:34], 0
);
    import gpioic_pkg::*;

    logic        in_valid_reg, in_valid_next;
    gpioic_req_t in_req_reg, in_req_next;
    logic        out_valid_reg, out_valid_next;
    gpioic_res_t out_res_reg, out_res_next;
    gpioic_res_t core_res;
    logic        accept;
    logic        advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_req_next.action     = gpioic_action_t'(s_axis_tuser);
        in_req_next.reg_addr   = s_axis_tdata[6:0];
        in_req_next.write_data = s_axis_tdata[38:7];
        in_req_next.pin_levels = s_axis_tdata[70:39];
        in_valid_next          = accept || (in_valid_reg && !advance);
        out_valid_next         = advance || (out_valid_reg && !m_axis_tready);
        out_res_next           = core_res;
    end

    gpioic_core #(
        .NUM_PINS   (NUM_PINS),
        .VERSION_ID (VERSION_ID)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (advance),
        .req       (in_req_reg),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg <= in_req_next;
        end
        if (advance)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg.lowest_pending, out_res_reg.pending_any,
                            out_res_reg.irq_line, out_res_reg.read_data};

endmodule

>>> design/gpioic_checker.sv
// Port-level checks for the GPIO interrupt controller, bound to its top level.
// Depends only on the ports of gpio_interrupt_controller.
module gpioic_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // Pending flag and interrupt line come from the same status word
    a_irq_matches_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32] == m_axis_tdata[33]))
        else $error("irq_line and pending_any disagree");

    // No pending pin reports index zero
    a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[33]) |-> (m_axis_tdata[38:34] == 5'd0))
        else $error("lowest_pending nonzero with nothing pending");

    // A fresh result follows a request that passed the input register, then the result register
    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without a request");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind gpio_interrupt_controller gpioic_port_checks u_gpioic_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/gpioic_checker.sv
`timescale 1ns / 100ps
// Result checker for gpio_interrupt_controller: mirrors the per-pin state from the
// requests seen on s_axis and compares every m_axis result. Depends on gpioic_pkg.
module gpioic_checker #(
    parameter int          NUM_PINS   = gpioic_pkg::NUM_PINS_DEFAULT,
    parameter logic [31:0] VERSION_ID = gpioic_pkg::VERSION_ID_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // reg_addr, write_data, pin_levels, 0
    input  logic [1:0]  s_axis_tuser,  // action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,  // read_data, irq_line, pending_any, lowest_pending, 0
    output int          mismatches,
    output int          outstanding
);
    import gpioic_pkg::*;

    localparam logic [31:0] PIN_MASK = (NUM_PINS >= 32) ? 32'hFFFF_FFFF
                                                         : ((32'h1 << NUM_PINS) - 32'h1);

    logic [31:0] en_q       = '0;
    logic [31:0] msk_q      = '0;
    logic [31:0] etype_q    = '0;
    logic [31:0] pol_q      = '0;
    logic [31:0] both_q     = '0;
    logic [31:0] last_pins  = '0;
    logic [31:0] held_edges = '0;

    gpioic_res_t expected_results[$];
    int          fail_count = 0;
    int          waiting    = 0;

    assign mismatches  = fail_count;
    assign outstanding = waiting;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("checker: %s: expected 0x%08h, got 0x%08h", what, want, got);
        fail_count++;
    endtask

    // Upper 16 bits of the write data enable the lower 16, placed in one half.
    function automatic logic [31:0] write_half(input logic [31:0] old, input logic [31:0] wd,
                                               input logic hi);
        logic [31:0] we;
        logic [31:0] d;
        we = {16'h0, wd[31:16]};
        d  = {16'h0, wd[15:0]};
        if (hi)
        begin
            we = we << 16;
            d  = d << 16;
        end
        return ((old & ~we) | (d & we)) & PIN_MASK;
    endfunction

    function automatic logic [31:0] read_half(input logic [31:0] v, input logic hi);
        return hi ? {16'h0, v[31:16]} : {16'h0, v[15:0]};
    endfunction

    function automatic logic [31:0] raw_pending();
        logic [31:0] edge_pins;
        edge_pins = etype_q | both_q;
        return en_q & ((held_edges & edge_pins) | (~edge_pins & ~(last_pins ^ pol_q)))
               & PIN_MASK;
    endfunction

    task automatic model_request(input gpioic_req_t rq, output gpioic_res_t rs);
        logic [6:0]  addr;
        logic [6:0]  base;
        logic        hi;
        logic [31:0] rd;
        logic [31:0] pins;
        logic [31:0] rise;
        logic [31:0] fall;
        logic [31:0] hit;
        logic [31:0] st;
        addr = rq.reg_addr & 7'h7C;
        base = addr & 7'h78;
        hi   = addr[2];
        rd   = '0;
        pins = rq.pin_levels & PIN_MASK;
        case (rq.action)
            ACT_WRITE:
            begin
                case (base)
                    ADDR_ENABLE_LO:   en_q    = write_half(en_q, rq.write_data, hi);
                    ADDR_MASK_LO:     msk_q   = write_half(msk_q, rq.write_data, hi);
                    ADDR_TYPE_LO:     etype_q = write_half(etype_q, rq.write_data, hi);
                    ADDR_POLARITY_LO: pol_q   = write_half(pol_q, rq.write_data, hi);
                    ADDR_BOTH_LO:     both_q  = write_half(both_q, rq.write_data, hi);
                    ADDR_EOI_LO:      held_edges = held_edges & ~write_half('0, rq.write_data, hi);
                    default: ;
                endcase
            end
            ACT_READ:
            begin
                case (base)
                    ADDR_ENABLE_LO:   rd = read_half(en_q, hi);
                    ADDR_MASK_LO:     rd = read_half(msk_q, hi);
                    ADDR_TYPE_LO:     rd = read_half(etype_q, hi);
                    ADDR_POLARITY_LO: rd = read_half(pol_q, hi);
                    ADDR_BOTH_LO:     rd = read_half(both_q, hi);
                    default:
                    begin
                        if (addr == ADDR_STATUS)
                            rd = raw_pending() & ~msk_q;
                        else if (addr == ADDR_RAW_STATUS)
                            rd = raw_pending();
                        else if (addr == ADDR_VERSION)
                            rd = VERSION_ID;
                    end
                endcase
            end
            ACT_TICK:
            begin
                rise = pins & ~last_pins;
                fall = ~pins & last_pins;
                hit  = (both_q & (rise | fall))
                     | (~both_q & etype_q & ((pol_q & rise) | (~pol_q & fall)));
                held_edges = held_edges | (hit & en_q & PIN_MASK);
                last_pins  = pins;
            end
            default: ;
        endcase
        st = raw_pending() & ~msk_q;
        rs.read_data      = rd;
        rs.irq_line       = |st;
        rs.pending_any    = |st;
        rs.lowest_pending = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (st[i])
                rs.lowest_pending = i[4:0];
        end
    endtask

    always @(posedge clk)
    begin
        gpioic_req_t rq;
        gpioic_res_t got;
        gpioic_res_t want;
        gpioic_res_t pred;
        if (!rst_n)
        begin
            en_q       = '0;
            msk_q      = '0;
            etype_q    = '0;
            pol_q      = '0;
            both_q     = '0;
            last_pins  = '0;
            held_edges = '0;
            expected_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.read_data      = m_axis_tdata[31:0];
                got.irq_line       = m_axis_tdata[32];
                got.pending_any    = m_axis_tdata[33];
                got.lowest_pending = m_axis_tdata[38:34];
                if (expected_results.size() == 0)
                    report_mismatch("result with no request", '0, got.read_data);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", want.read_data, got.read_data);
                    if (got.irq_line !== want.irq_line)
                        report_mismatch("irq_line", 32'(want.irq_line), 32'(got.irq_line));
                    if (got.pending_any !== want.pending_any)
                        report_mismatch("pending_any", 32'(want.pending_any),
                                        32'(got.pending_any));
                    if (got.lowest_pending !== want.lowest_pending)
                        report_mismatch("lowest_pending", 32'(want.lowest_pending),
                                        32'(got.lowest_pending));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                rq.action     = gpioic_action_t'(s_axis_tuser);
                rq.reg_addr   = s_axis_tdata[6:0];
                rq.write_data = s_axis_tdata[38:7];
                rq.pin_levels = s_axis_tdata[70:39];
                model_request(rq, pred);
                expected_results.push_back(pred);
            end
        end
        waiting = expected_results.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for gpio_interrupt_controller: clock, reset, request stimulus
// and result back-pressure. Depends on gpioic_pkg, gpioic_checker and gpio_interrupt_controller.
module tb;
    import gpioic_pkg::*;

    localparam logic [1:0] ACT_RESERVED  = 2'd3;
    localparam logic [6:0] ADDR_DATA     = 7'h00;
    localparam logic [6:0] ADDR_UNMAPPED = 7'h7C;
    localparam int         CYCLE_LIMIT   = 400000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    int          mismatches;
    int          outstanding;
    int          idle_pct  = 0;
    int          hold_left = 0;
    int          cycles    = 0;
    logic        req_fire  = 1'b0;
    logic [31:0] pins_now  = '0;

    gpio_interrupt_controller i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    gpioic_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        req_fire <= s_axis_tvalid && s_axis_tready;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Stall the result side in random bursts.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 2)
        begin
            hold_left = $urandom_range(11, 0);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic logic [6:0] map_addr(input int k);
        case (k)
            0:       return ADDR_ENABLE_LO;
            1:       return ADDR_ENABLE_HI;
            2:       return ADDR_MASK_LO;
            3:       return ADDR_MASK_HI;
            4:       return ADDR_TYPE_LO;
            5:       return ADDR_TYPE_HI;
            6:       return ADDR_POLARITY_LO;
            7:       return ADDR_POLARITY_HI;
            8:       return ADDR_BOTH_LO;
            9:       return ADDR_BOTH_HI;
            10:      return ADDR_STATUS;
            11:      return ADDR_RAW_STATUS;
            12:      return ADDR_EOI_LO;
            13:      return ADDR_EOI_HI;
            default: return ADDR_VERSION;
        endcase
    endfunction

    // Enter and leave at a falling edge; hold the request until it is taken.
    task automatic send_request(input logic [1:0] act, input logic [6:0] addr,
                                input logic [31:0] wdata, input logic [31:0] pins);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {1'b0, pins, wdata, addr};
        if (act == ACT_TICK)
            pins_now = pins;
        do @(negedge clk); while (!req_fire);
    endtask

    task automatic send_tick(input logic [31:0] pins);
        send_request(ACT_TICK, 7'($urandom_range(127, 0)), $urandom, pins);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic random_request();
        int          pick;
        logic [15:0] we;
        logic [31:0] d;
        logic [31:0] pins;
        pick = $urandom_range(99);
        we   = 16'($urandom);
        d    = $urandom;
        if ($urandom_range(1))
            we = 16'hFFFF;
        if (pick < 15)
            send_request(ACT_WRITE, map_addr($urandom_range(9, 0)), {we, d[15:0]}, $urandom);
        else if (pick < 21)
            send_request(ACT_WRITE, map_addr($urandom_range(13, 12)), {we, d[15:0]}, $urandom);
        else if (pick < 36)
            send_request(ACT_READ, map_addr($urandom_range(14, 0)), $urandom, $urandom);
        else if (pick < 91)
        begin
            case ($urandom_range(3))
                0:       pins = pins_now ^ (32'h1 << $urandom_range(31));
                1:       pins = pins_now ^ ($urandom & $urandom & $urandom);
                2:       pins = pins_now;
                default: pins = $urandom;
            endcase
            send_tick(pins);
        end
        else
            send_request(2'($urandom_range(3, 0)), 7'($urandom_range(127, 0)), $urandom,
                         $urandom);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(ACT_READ, ADDR_ENABLE_LO, '0, '0);
        send_request(ACT_READ, ADDR_STATUS, '0, '0);
        // level mode with low polarity: every pin pends as soon as it is enabled
        send_request(ACT_WRITE, ADDR_ENABLE_LO, 32'hFFFF_FFFF, '0);
        send_request(ACT_WRITE, ADDR_ENABLE_HI, 32'hFFFF_FFFF, '0);
        send_request(ACT_READ, ADDR_RAW_STATUS, '0, '0);
        send_request(ACT_WRITE, ADDR_MASK_LO, 32'h00FF_1234, '0);
        // no enable bits set: no change
        send_request(ACT_WRITE, ADDR_MASK_HI, 32'h0000_FFFF, '0);
        send_request(ACT_READ, ADDR_STATUS, '0, '0);
        send_request(ACT_WRITE, ADDR_TYPE_HI, 32'hFFFF_FFFF, '0);
        send_request(ACT_WRITE, ADDR_POLARITY_HI, 32'hFFFF_AAAA, '0);
        send_request(ACT_WRITE, ADDR_BOTH_LO, 32'h8001_8001, '0);
        // low address bits are dropped
        send_request(ACT_WRITE, ADDR_POLARITY_LO | 7'h01, 32'hFFFF_FFFF, '0);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'h0000_0000);
        send_tick(32'h5555_AAAA);
        send_request(ACT_READ, ADDR_RAW_STATUS, '0, '0);
        send_request(ACT_WRITE, ADDR_STATUS, 32'hFFFF_FFFF, '0);
        send_request(ACT_WRITE, ADDR_EOI_HI, 32'hFFFF_FFFF, '0);
        send_request(ACT_READ, ADDR_EOI_LO, '0, '0);
        send_request(ACT_READ, ADDR_VERSION, '0, '0);
        send_request(ACT_WRITE, ADDR_UNMAPPED, 32'hFFFF_FFFF, '0);
        send_request(ACT_READ, ADDR_DATA, '0, '0);
        send_request(ACT_READ, 7'h7F, '0, '0);
        send_request(ACT_RESERVED, ADDR_ENABLE_LO, 32'hFFFF_0000, 32'hFFFF_FFFF);
        send_request(ACT_WRITE, ADDR_ENABLE_LO, 32'hFFFF_0000, '0);
        send_request(ACT_READ, ADDR_ENABLE_LO | 7'h03, '0, '0);
        drain_results();

        idle_pct = 25;
        repeat (600) random_request();
        drain_results();
        idle_pct = 60;
        repeat (600) random_request();
        drain_results();
        idle_pct = 0;
        repeat (550) random_request();

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
